// ===== rtl/expr_lex_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// expr_lex_pkg
// Shared types, token codes and character classes of the expression lexer.
// ----------------------------------------------------------------------------
package expr_lex_pkg;

	localparam int CHAR_W          = 8;
	localparam int KIND_W          = 4;
	localparam int WHOLE_W         = 63;
	localparam int FRAC_W          = 60;
	localparam int CNT_W           = 5;
	localparam int ACC_W           = WHOLE_W + 4;
	localparam int FRAC_MAX_DIGITS = 18;
	localparam int MAX_IDENT_DEF   = 32;
	localparam int KW_REPEAT_LEN   = 6;
	localparam int KW_PRINT_LEN    = 5;

	localparam logic [KIND_W-1:0] K_INVALID = 4'd0;
	localparam logic [KIND_W-1:0] K_REPEAT  = 4'd1;
	localparam logic [KIND_W-1:0] K_PRINT   = 4'd2;
	localparam logic [KIND_W-1:0] K_IDENT   = 4'd3;
	localparam logic [KIND_W-1:0] K_INT     = 4'd4;
	localparam logic [KIND_W-1:0] K_FLOAT   = 4'd5;
	localparam logic [KIND_W-1:0] K_ASSIGN  = 4'd6;
	localparam logic [KIND_W-1:0] K_LPAREN  = 4'd7;
	localparam logic [KIND_W-1:0] K_RPAREN  = 4'd8;
	localparam logic [KIND_W-1:0] K_ADDOP   = 4'd9;
	localparam logic [KIND_W-1:0] K_MULTOP  = 4'd10;
	localparam logic [KIND_W-1:0] K_SEMI    = 4'd11;
	localparam logic [KIND_W-1:0] K_EOF     = 4'd12;

	typedef struct packed {
		logic [CHAR_W-1:0]  text_char;
		logic [CNT_W-1:0]   frac_count;
		logic [FRAC_W-1:0]  frac_value;
		logic [WHOLE_W-1:0] whole_value;
		logic [CHAR_W-1:0]  op_char;
	} token_data_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_ident_start(input logic [CHAR_W-1:0] c);
		return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) ||
			(c == "$") || (c == "_");
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
	endfunction

	function automatic logic [KIND_W-1:0] op_kind(input logic [CHAR_W-1:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			"=":             k = K_ASSIGN;
			";":             k = K_SEMI;
			"(":             k = K_LPAREN;
			")":             k = K_RPAREN;
			"+", "-":        k = K_ADDOP;
			"*", "/", "%":   k = K_MULTOP;
			default:         k = K_INVALID;
		endcase
		return k;
	endfunction

	function automatic logic [CHAR_W-1:0] repeat_char(input logic [2:0] i);
		logic [CHAR_W-1:0] c;
		unique case (i)
			3'd0:    c = "r";
			3'd1:    c = "e";
			3'd2:    c = "p";
			3'd3:    c = "e";
			3'd4:    c = "a";
			3'd5:    c = "t";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] print_char(input logic [2:0] i);
		logic [CHAR_W-1:0] c;
		unique case (i)
			3'd0:    c = "p";
			3'd1:    c = "r";
			3'd2:    c = "i";
			3'd3:    c = "n";
			3'd4:    c = "t";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/expr_lex_mac10.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// expr_lex_mac10
// Shared decimal accumulate unit: acc * 10 + digit, saturating at 2^63-1.
// ----------------------------------------------------------------------------
module expr_lex_mac10
	import expr_lex_pkg::*;
(
	input  logic [WHOLE_W-1:0] acc,
	input  logic [3:0]         digit,
	output logic [WHOLE_W-1:0] result
);

	logic [ACC_W-1:0] wide;

	assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + ACC_W'(digit);

	always_comb begin
		if (wide[ACC_W-1:WHOLE_W] != '0) begin
			result = '1;
		end else begin
			result = wide[WHOLE_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/expression_lexer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// expression_lexer
// Character-at-a-time scanner: identifiers, keywords, saturating integers,
// floats whose fraction keeps at most 18 digits, operators and punctuation.
// ----------------------------------------------------------------------------
// With no token pending, a character is accepted in ST_IDLE, classified in
// ST_DECIDE and in ST_START starts a token or emits an operator, punctuation
// or end token. A character that continues an identifier, integer or fraction
// is accepted and classified and then the sequencer returns to idle, with a
// digit passing through the single multiply-by-ten adder shared by the integer
// and fraction accumulators. A character that ends a pending integer, float or
// keyword first has it emitted in ST_PEND before the character is started. A
// pending plain identifier goes from ST_PEND through ST_RD and ST_EMIT for each
// buffered character, ST_RD using the buffer's registered read port. Every emit
// also waits while the output register holds a transaction that m_tready has
// not taken. s_tready is high only while the sequencer is idle. The identifier
// buffer needs no clearing pass after reset.
module expression_lexer
	import expr_lex_pkg::*;
#(
	parameter int MAX_IDENT = MAX_IDENT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // ch
	input  logic         s_tuser,   // at_end
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // op_char, whole_value, frac_value, frac_count, text_char
	output logic [3:0]   m_tuser,   // token_kind
	output logic         m_tlast    // last
);

	localparam int IDX_W = $clog2(MAX_IDENT);
	localparam int LEN_W = $clog2(MAX_IDENT + 1);

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_IDENT = 2'd1;
	localparam logic [1:0] MODE_INT   = 2'd2;
	localparam logic [1:0] MODE_FRAC  = 2'd3;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_PEND   = 3'd2;
	localparam logic [2:0] ST_RD     = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;
	localparam logic [2:0] ST_START  = 3'd5;

	logic [2:0]         state_q;
	logic [1:0]         mode_q;
	logic [CHAR_W-1:0]  ch_q;
	logic               end_q;
	logic [WHOLE_W-1:0] whole_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [CNT_W-1:0]   frac_digits_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   idx_q;
	logic               rep_ok_q;
	logic               prn_ok_q;

	logic [CHAR_W-1:0]  ident_mem [MAX_IDENT];
	logic [CHAR_W-1:0]  rdata_q;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;

	logic               m_tvalid_q;
	token_data_t        tok_q;
	logic [KIND_W-1:0]  kind_q;
	logic               last_q;

	token_data_t        tok_d;
	logic [KIND_W-1:0]  kind_d;
	logic               last_d;
	logic               emit_en;
	logic               out_free;

	logic [WHOLE_W-1:0] unit_acc;
	logic [WHOLE_W-1:0] unit_res;
	logic               is_kw_rep;
	logic               is_kw_prn;
	logic               idx_last;
	logic               len_room;
	logic               ch_ident;
	logic               ch_digit;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = tok_q;
	assign m_tuser   = kind_q;
	assign m_tlast   = last_q;
	assign out_free  = !m_tvalid_q || m_tready;

	assign ch_ident  = is_ident_start(ch_q) || is_digit(ch_q);
	assign ch_digit  = is_digit(ch_q);
	assign len_room  = (len_q < LEN_W'(MAX_IDENT));
	assign is_kw_rep = rep_ok_q && (len_q == LEN_W'(KW_REPEAT_LEN));
	assign is_kw_prn = prn_ok_q && (len_q == LEN_W'(KW_PRINT_LEN));
	assign idx_last  = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);

	// shared accumulate unit
	assign unit_acc = (mode_q == MODE_FRAC) ? WHOLE_W'(frac_q) : whole_q;

	expr_lex_mac10 u_mac10 (
		.acc    (unit_acc),
		.digit  (ch_q[3:0]),
		.result (unit_res)
	);

	// identifier buffer
	assign wr_en = (!end_q && (
		((state_q == ST_DECIDE) && (mode_q == MODE_IDENT) && ch_ident && len_room) ||
		((state_q == ST_START) && is_ident_start(ch_q))));
	assign wr_addr = (state_q == ST_START) ? '0 : len_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ident_mem[wr_addr] <= ch_q;
		end
		if (state_q == ST_RD) begin
			rdata_q <= ident_mem[idx_q];
		end
	end

	// token to emit in this cycle
	always_comb begin
		tok_d   = '0;
		kind_d  = K_INVALID;
		last_d  = 1'b1;
		emit_en = 1'b0;
		unique case (state_q)
			ST_PEND: begin
				if (mode_q == MODE_IDENT) begin
					if (is_kw_rep) begin
						kind_d  = K_REPEAT;
						emit_en = out_free;
					end else if (is_kw_prn) begin
						kind_d  = K_PRINT;
						emit_en = out_free;
					end
				end else if (mode_q == MODE_INT) begin
					kind_d            = K_INT;
					tok_d.whole_value = whole_q;
					emit_en           = out_free;
				end else if (mode_q == MODE_FRAC) begin
					kind_d            = K_FLOAT;
					tok_d.whole_value = whole_q;
					tok_d.frac_value  = frac_q;
					tok_d.frac_count  = frac_digits_q;
					emit_en           = out_free;
				end
			end
			ST_EMIT: begin
				kind_d          = K_IDENT;
				tok_d.text_char = rdata_q;
				last_d          = idx_last;
				emit_en         = out_free;
			end
			ST_START: begin
				if (end_q) begin
					kind_d  = K_EOF;
					emit_en = out_free;
				end else if (!is_space(ch_q) && !is_ident_start(ch_q) && !ch_digit) begin
					kind_d        = op_kind(ch_q);
					tok_d.op_char = ch_q;
					emit_en       = out_free;
				end
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			tok_q  <= tok_d;
			kind_q <= kind_d;
			last_q <= last_d;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= MODE_IDLE;
			ch_q          <= '0;
			end_q         <= 1'b0;
			whole_q       <= '0;
			frac_q        <= '0;
			frac_digits_q <= '0;
			len_q         <= '0;
			idx_q         <= '0;
			rep_ok_q      <= 1'b0;
			prn_ok_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ch_q    <= s_tdata;
						end_q   <= s_tuser;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					priority if (end_q) begin
						state_q <= (mode_q == MODE_IDLE) ? ST_START : ST_PEND;
					end else if (mode_q == MODE_IDLE) begin
						state_q <= ST_START;
					end else if ((mode_q == MODE_IDENT) && ch_ident) begin
						if (len_room) begin
							len_q <= len_q + LEN_W'(1);
							if (len_q < LEN_W'(KW_REPEAT_LEN)) begin
								rep_ok_q <= rep_ok_q && (ch_q == repeat_char(len_q[2:0]));
							end
							if (len_q < LEN_W'(KW_PRINT_LEN)) begin
								prn_ok_q <= prn_ok_q && (ch_q == print_char(len_q[2:0]));
							end
						end
						state_q <= ST_IDLE;
					end else if ((mode_q == MODE_INT) && ch_digit) begin
						whole_q <= unit_res;
						state_q <= ST_IDLE;
					end else if ((mode_q == MODE_INT) && (ch_q == ".")) begin
						mode_q  <= MODE_FRAC;
						state_q <= ST_IDLE;
					end else if ((mode_q == MODE_FRAC) && ch_digit) begin
						if (frac_digits_q < CNT_W'(FRAC_MAX_DIGITS)) begin
							frac_q        <= unit_res[FRAC_W-1:0];
							frac_digits_q <= frac_digits_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_PEND;
					end
				end
				ST_PEND: begin
					if ((mode_q == MODE_IDENT) && !is_kw_rep && !is_kw_prn) begin
						idx_q   <= '0;
						state_q <= ST_RD;
					end else if (emit_en) begin
						mode_q  <= MODE_IDLE;
						state_q <= ST_START;
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_en) begin
						if (idx_last) begin
							mode_q  <= MODE_IDLE;
							state_q <= ST_START;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_START: begin
					priority if (end_q) begin
						if (emit_en) begin
							state_q <= ST_IDLE;
						end
					end else if (is_space(ch_q)) begin
						state_q <= ST_IDLE;
					end else if (is_ident_start(ch_q)) begin
						mode_q   <= MODE_IDENT;
						len_q    <= LEN_W'(1);
						rep_ok_q <= (ch_q == repeat_char(3'd0));
						prn_ok_q <= (ch_q == print_char(3'd0));
						state_q  <= ST_IDLE;
					end else if (ch_digit) begin
						mode_q        <= MODE_INT;
						whole_q       <= WHOLE_W'(ch_q[3:0]);
						frac_q        <= '0;
						frac_digits_q <= '0;
						state_q       <= ST_IDLE;
					end else begin
						if (emit_en) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_IDENT))
		else $error("identifier length beyond buffer");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frac_digits_q <= CNT_W'(FRAC_MAX_DIGITS))
		else $error("fraction digit count beyond limit");

	a_ident_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDENT) |-> (len_q != '0))
		else $error("identifier mode with empty buffer");

	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (LEN_W'(idx_q) < len_q))
		else $error("flush index past identifier length");

	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DECIDE))
		else $error("accepted transaction not classified next cycle");
`endif

endmodule
`default_nettype wire
